[rtl/core/wpau_pkg.sv]
// shared types and constants of the walking pattern avoidance update block
// no dependencies
package wpau_pkg;

  localparam int DEF_MAX_SIZE    = 64;
  localparam int DEF_MAX_WALK    = 64;
  localparam int DEF_QUEUE_DEPTH = 8192;

  localparam int PROG_W    = 6;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WALK_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_VALUES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_DIRECTIONS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE     = 2'd3;

  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic read;
    logic calc;
    logic push_right;
  } wpau_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic finish;
  } wpau_sts_t;

endpackage

[rtl/core/wpau_ctrl.sv]
// sequencer of the walking pattern avoidance update block
// depends on wpau_pkg
module wpau_ctrl import wpau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  wpau_sts_t sts,
  output wpau_cmd_t cmd,
  output logic      busy
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CALC  = 3'd4;
  localparam logic [2:0] ST_PUSHR = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_next = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_next = sts.hit ? ST_IDLE : ST_PUSHR;
      end
      ST_PUSHR: begin
        cmd.push_right = 1'b1;
        state_next = sts.finish ? ST_IDLE : ST_FETCH;
      end
      default: state_next = ST_IDLE;
    endcase
    // out of range cell: result right away, stay idle
    if (state == ST_IDLE && start && !sts.finish) state_next = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/wpau_dp.sv]
// datapath: matrix and progress memories, work list, walk step logic
// depends on wpau_pkg
module wpau_dp import wpau_pkg::*; #(
  parameter int MAX_SIZE    = DEF_MAX_SIZE,
  parameter int MAX_WALK    = DEF_MAX_WALK,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int RW = $clog2(MAX_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wpau_cmd_t            cmd,
  output wpau_sts_t            sts,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [RW-1:0]        cell_row,
  input  logic [RW-1:0]        cell_col,
  input  logic                 cell_value,
  output logic                 done,
  output logic                 pattern_avoided,
  output logic                 work_overflow
);

  localparam int AW    = 2 * RW;
  localparam int CELLS = 1 << AW;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);

  // configuration
  logic [6:0]       walk_length;
  logic [CFG_W-1:0] walk_values;
  logic [CFG_W-1:0] walk_directions;
  logic [6:0]       matrix_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_length     <= 7'd1;
      walk_values     <= '0;
      walk_directions <= '0;
      matrix_size     <= 7'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WALK_LENGTH:     walk_length     <= cfg_data[6:0];
        REG_WALK_VALUES:     walk_values     <= cfg_data;
        REG_WALK_DIRECTIONS: walk_directions <= cfg_data;
        REG_MATRIX_SIZE:     matrix_size     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [8:0] msz9;
  logic [8:0] n_eff;
  logic [6:0] len_eff;

  always_comb begin
    msz9 = {2'b00, matrix_size};
    if (msz9 == 9'd0) n_eff = 9'd1;
    else if (msz9 > 9'(MAX_SIZE)) n_eff = 9'(MAX_SIZE);
    else n_eff = msz9;
    if (walk_length == 7'd0) len_eff = 7'd1;
    else if (walk_length > 7'(MAX_WALK)) len_eff = 7'(MAX_WALK);
    else len_eff = walk_length;
  end

  // memories
  logic              bmem [CELLS];
  logic [PROG_W-1:0] vmem [CELLS];
  logic [PROG_W-1:0] hmem [CELLS];
  logic [AW-1:0]     qmem [QUEUE_DEPTH];

  logic [AW-1:0] clr_cnt;
  logic [QW-1:0] head;
  logic [QW-1:0] wr_ptr;
  logic [CW-1:0] count;
  logic [AW-1:0] tail;
  logic [AW-1:0] q_rdata;
  logic [AW-1:0] cur;
  logic          over;

  logic              b_cur;
  logic [PROG_W-1:0] v_cur, v_up, h_cur, h_left;

  logic [AW-1:0] in_cell;
  logic          in_range;
  assign in_cell  = {cell_row, cell_col};
  assign in_range = (9'(cell_row) < n_eff) && (9'(cell_col) < n_eff);

  logic [RW-1:0] cr, cc, qr, qc;
  assign cr = cur[AW-1:RW];
  assign cc = cur[RW-1:0];
  assign qr = q_rdata[AW-1:RW];
  assign qc = q_rdata[RW-1:0];

  always_ff @(posedge clk) begin
    b_cur  <= bmem[q_rdata];
    v_cur  <= vmem[q_rdata];
    h_cur  <= hmem[q_rdata];
    v_up   <= vmem[{qr - RW'(1), qc}];
    h_left <= hmem[{qr, qc - RW'(1)}];
  end

  // walk step at the current cell
  logic [PROG_W-1:0] up, left, k1, k2, nv, nh;
  logic              q1, q2, hit;
  logic [6:0]        k1p, k2p;

  always_comb begin
    up   = (cr == '0) ? '0 : v_up;
    left = (cc == '0) ? '0 : h_left;
    nv = up;
    nh = left;
    k1 = up;
    k1p = {1'b0, k1} + 7'd1;
    q1 = b_cur | ~walk_values[k1];
    hit = q1 && (k1p >= len_eff);
    if (q1 && !hit) begin
      if (walk_directions[k1]) begin
        if ({1'b0, nh} < k1p) nh = k1p[PROG_W-1:0];
      end else begin
        if ({1'b0, nv} < k1p) nv = k1p[PROG_W-1:0];
      end
    end
    k2 = left;
    k2p = {1'b0, k2} + 7'd1;
    q2 = b_cur | ~walk_values[k2];
    if (!hit && q2) begin
      if (k2p >= len_eff) begin
        hit = 1'b1;
      end else if (walk_directions[k2]) begin
        if ({1'b0, nh} < k2p) nh = k2p[PROG_W-1:0];
      end else begin
        if ({1'b0, nv} < k2p) nv = k2p[PROG_W-1:0];
      end
    end
  end

  // work list pushes
  logic          full, push_req, push_ok;
  logic [AW-1:0] push_cell;
  logic [AW-1:0] down_cell, right_cell;
  logic          down_req, right_req;

  assign down_cell  = {cr + RW'(1), cc};
  assign right_cell = {cr, cc + RW'(1)};
  assign full       = (count == CW'(QUEUE_DEPTH));
  assign down_req   = (nv != v_cur) && (9'(cr) + 9'd1 < n_eff)
                      && !((count != '0) && (tail == down_cell));
  assign right_req  = (nh != h_cur) && (9'(cc) + 9'd1 < n_eff);

  always_comb begin
    push_req  = 1'b0;
    push_cell = right_cell;
    if (cmd.calc && !hit) begin
      push_req  = down_req;
      push_cell = down_cell;
    end else if (cmd.push_right) begin
      push_req = right_req;
    end
  end
  assign push_ok = push_req && !full;

  assign sts.clear_last = (clr_cnt == '1);
  assign sts.hit        = hit;
  // in idle, finish reports whether the offered cell lies in the matrix
  assign sts.finish     = cmd.push_right ? ((count == '0) && !push_ok) : in_range;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      bmem[clr_cnt] <= 1'b0;
    end else if (cmd.accept && in_range) begin
      bmem[in_cell] <= cell_value;
    end
    if (cmd.clear) begin
      vmem[clr_cnt] <= '0;
      hmem[clr_cnt] <= '0;
    end else if (cmd.calc) begin
      vmem[cur] <= nv;
      hmem[cur] <= nh;
    end
    if (cmd.accept) begin
      qmem[0] <= in_cell;
    end else if (push_ok) begin
      qmem[wr_ptr] <= push_cell;
    end
    if (cmd.fetch) q_rdata <= qmem[head];
    if (cmd.read) cur <= q_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt         <= '0;
      count           <= '0;
      head            <= '0;
      wr_ptr          <= '0;
      over            <= 1'b0;
      done            <= 1'b0;
      pattern_avoided <= 1'b1;
      work_overflow   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.clear) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.accept) begin
        head   <= '0;
        wr_ptr <= QW'(1);
        count  <= CW'(1);
        tail   <= in_cell;
        over   <= 1'b0;
        if (!in_range) begin
          done            <= 1'b1;
          pattern_avoided <= 1'b1;
          work_overflow   <= 1'b0;
        end
      end
      if (cmd.fetch) begin
        head  <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
        count <= count - CW'(1);
      end
      if (push_ok) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
        count  <= count + CW'(1);
        tail   <= push_cell;
      end
      if (push_req && full) over <= 1'b1;
      if (cmd.calc && hit) begin
        done            <= 1'b1;
        pattern_avoided <= 1'b0;
        work_overflow   <= over;
      end
      if (cmd.push_right && sts.finish) begin
        done            <= 1'b1;
        pattern_avoided <= 1'b1;
        work_overflow   <= over | (push_req && full);
      end
    end
  end

endmodule

[rtl/core/walking_pattern_avoidance_update.sv]
// top level of the walking pattern avoidance update block
// depends on wpau_pkg, wpau_ctrl, wpau_dp
//
// usage
// - a cell write (cell_row, cell_col, cell_value) is taken at a rising edge
//   with start high and busy low
// - one result word per accepted write: pattern_avoided and work_overflow
//   are valid for the single cycle in which done is high; the receiver
//   cannot stall, so no back pressure exists
// - a cell outside the matrix in use gives its result the next cycle
// - otherwise each cell taken off the work list goes through list read,
//   memory read, step compute with down push and right push; the right
//   push is skipped when the walk completes, busy high throughout; the
//   visited region is data dependent
// - the cfg port writes registers (walk_length, walk_values,
//   walk_directions, matrix_size) by index; the user writes them only
//   while idle, the block itself does not enforce it
// - after reset a clearing pass zeroes the matrix and progress memories,
//   one cell a cycle, MAX_SIZE rounded up to a power of two, squared, cells
//   (4096 at defaults); busy stays high meanwhile, config writes still taken
module walking_pattern_avoidance_update import wpau_pkg::*; #(
  parameter int MAX_SIZE    = DEF_MAX_SIZE,
  parameter int MAX_WALK    = DEF_MAX_WALK,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int RW = $clog2(MAX_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [RW-1:0]        cell_row,
  input  logic [RW-1:0]        cell_col,
  input  logic                 cell_value,
  output logic                 done,
  output logic                 pattern_avoided,
  output logic                 work_overflow,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  wpau_cmd_t cmd;
  wpau_sts_t sts;

  // sequencer: clearing pass, then list fetch / read / compute / push loop
  wpau_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // memories, work list and the per cell step
  wpau_dp #(
    .MAX_SIZE    (MAX_SIZE),
    .MAX_WALK    (MAX_WALK),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cell_row        (cell_row),
    .cell_col        (cell_col),
    .cell_value      (cell_value),
    .done            (done),
    .pattern_avoided (pattern_avoided),
    .work_overflow   (work_overflow)
  );

endmodule

[rtl/core/wpau_checker.sv]
// port level checks of the walking pattern avoidance update block
// depends on walking_pattern_avoidance_update (bound below)
module wpau_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic work_overflow
);

  // a result only follows an accepted word or ongoing work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an accepted word");

  // clearing pass holds busy right after reset
  a_clear_busy: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

  // overflow only after work: busy was high before the result
  a_over_busy: assert property (@(posedge clk) disable iff (rst)
    (done && work_overflow) |-> $past(busy))
    else $error("overflow without work");

endmodule

bind walking_pattern_avoidance_update wpau_checker u_wpau_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .work_overflow (work_overflow)
);
